>>> design/ptd_pkg.sv
// ----------------------------------------------------------------------------
// ptd_pkg - palette texel decoder shared definitions
// Formats, commands, register indexes, pipeline operation type and the
// colour helper functions used by the decoder.
// ----------------------------------------------------------------------------
package ptd_pkg;

  // Palette memory geometry (entry count is a power of two)
  localparam int PALETTE_ENTRIES = 65536;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int ADDR_SUM_W      = 17;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Sequencer: up to four palette reads plus sixteen texels per block
  localparam int MAX_OPS = 20;
  localparam int STEP_W  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXTURE_FORMAT = 2'd0,
    CFG_PALETTE_BASE   = 2'd1,
    CFG_COLOR0_TRANSP  = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    FMT_NONE   = 3'd0,
    FMT_A3I5   = 3'd1,
    FMT_PAL2   = 3'd2,
    FMT_PAL4   = 3'd3,
    FMT_PAL8   = 3'd4,
    FMT_BLOCK  = 3'd5,
    FMT_A5I3   = 3'd6,
    FMT_DIRECT = 3'd7
  } fmt_t;

  typedef enum logic {
    CMD_PAL_WRITE = 1'b0,
    CMD_DECODE    = 1'b1
  } cmd_t;

  // Compressed block modes
  typedef enum logic [1:0] {
    MODE_P3_ZERO  = 2'd0,
    MODE_AVG      = 2'd1,
    MODE_FOUR     = 2'd2,
    MODE_BLEND53  = 2'd3
  } blk_mode_t;

  // One pipeline operation issued per cycle while the pipeline advances
  typedef enum logic [2:0] {
    OP_NONE        = 3'd0,
    OP_WRITE       = 3'd1,
    OP_LOAD        = 3'd2,
    OP_EMIT_PAL    = 3'd3,
    OP_EMIT_DIRECT = 3'd4,
    OP_EMIT_BLOCK  = 3'd5
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [3:0]  slot;
    logic        last;
    logic [7:0]  alpha;
    logic        clear;   // transparent colour 0
    logic [14:0] color;   // direct colour
    logic [1:0]  sel;     // block load target or texel index
    blk_mode_t   mode;
  } op_t;

  // 5-bit channel to 8 bits
  function automatic logic [7:0] expand5(input logic [4:0] c);
    return {c, c[4:2]};
  endfunction

  // BGR555 to ARGB8888
  function automatic logic [31:0] to_argb(input logic [14:0] c, input logic [7:0] a);
    return {a, expand5(c[4:0]), expand5(c[9:5]), expand5(c[14:10])};
  endfunction

  // Per-channel average, opaque
  function automatic logic [31:0] blend_avg(input logic [31:0] c0, input logic [31:0] c1);
    logic [31:0] res;
    logic [8:0]  sum;
    res = 32'hFF00_0000;
    for (int s = 0; s < 3; s++) begin
      sum = {1'b0, c0[8*s +: 8]} + {1'b0, c1[8*s +: 8]};
      res[8*s +: 8] = sum[8:1];
    end
    return res;
  endfunction

  // Per-channel (5*c0 + 3*c1) >> 3, opaque
  function automatic logic [31:0] blend_53(input logic [31:0] c0, input logic [31:0] c1);
    logic [31:0] res;
    logic [10:0] a;
    logic [10:0] b;
    logic [10:0] sum;
    res = 32'hFF00_0000;
    for (int s = 0; s < 3; s++) begin
      a   = {3'b0, c0[8*s +: 8]};
      b   = {3'b0, c1[8*s +: 8]};
      sum = (a << 2) + a + (b << 1) + b;
      res[8*s +: 8] = sum[10:3];
    end
    return res;
  endfunction

endpackage

>>> design/palette_texel_decoder_unit.sv
// ----------------------------------------------------------------------------
// palette_texel_decoder_unit - texture format decoder with palette memory
// Palette writes fill a single-port palette RAM; decode requests become
// ARGB8888 texels via a three-stage pipeline, at most one per unstalled cycle.
// ----------------------------------------------------------------------------
// An issue sequencer turns each request into one operation per cycle, and the
// single palette RAM port serves one operation per cycle, both while the
// output does not stall. A palette write, A3I5, A5I3, pal8 or direct texel
// is one operation, pal4 is two, pal2 is four, and a compressed 4x4 block
// is 18 to 20 (2, 3 or 4 palette reads by mode, then 16 texels). A new
// request is taken in the cycle the previous one issues its last operation.
// The first texel passes from the issue stage through the read stage to the
// output register, after a compressed block's palette reads. The palette
// RAM has no reset and needs no clearing pass; entries must be written before
// they are read. The user must write config only while idle (not enforced).
// ----------------------------------------------------------------------------
module palette_texel_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]  cfg_data,
  // requests
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            command,
  input  logic [31:0]                     texel_data,
  input  logic [15:0]                     tile_info,
  input  logic [15:0]                     palette_index,
  input  logic [15:0]                     palette_value,
  // texels
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     texel_color,
  output logic [3:0]                      texel_slot,
  output logic                            last_texel
);
  import ptd_pkg::*;

  // Configuration registers
  fmt_t        texture_format;
  logic [12:0] pal_window;
  logic        zero_is_clear;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      texture_format <= FMT_NONE;
      pal_window     <= '0;
      zero_is_clear  <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TEXTURE_FORMAT: texture_format <= fmt_t'(cfg_data[2:0]);
        CFG_PALETTE_BASE:   pal_window     <= cfg_data[12:0];
        CFG_COLOR0_TRANSP:  zero_is_clear  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves when the output register is free
  logic adv;
  logic in_accept;
  assign adv = !out_valid || out_ready;

  // Issue stage: held request and operation counter
  logic              s0_valid;
  logic [STEP_W-1:0] step;
  cmd_t              s0_cmd;
  logic [31:0]       s0_data;
  logic [15:0]       s0_info;
  logic [15:0]       s0_pidx;
  logic [15:0]       s0_pval;

  logic [STEP_W-1:0] n_ops;
  logic [2:0]        n_reads;
  logic              s0_last;

  // Number of block palette reads by mode
  always_comb begin
    unique case (blk_mode_t'(s0_info[15:14]))
      MODE_P3_ZERO: n_reads = 3'd3;
      MODE_AVG:     n_reads = 3'd2;
      MODE_FOUR:    n_reads = 3'd4;
      MODE_BLEND53: n_reads = 3'd2;
      default:      n_reads = 3'd2;
    endcase
  end

  // Operations per request
  always_comb begin
    n_ops = STEP_W'(1);
    if (s0_cmd == CMD_DECODE) begin
      unique case (texture_format)
        FMT_PAL4:  n_ops = STEP_W'(2);
        FMT_PAL2:  n_ops = STEP_W'(4);
        FMT_BLOCK: n_ops = STEP_W'(n_reads) + STEP_W'(16);
        default:   n_ops = STEP_W'(1);
      endcase
    end
  end

  assign s0_last   = (step >= n_ops - STEP_W'(1));
  assign in_ready  = adv && (!s0_valid || s0_last);
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      step     <= '0;
    end else if (in_accept) begin
      s0_valid <= 1'b1;
      step     <= '0;
    end else if (adv && s0_valid) begin
      if (s0_last) begin
        s0_valid <= 1'b0;
      end else begin
        step <= step + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s0_cmd  <= cmd_t'(command);
      s0_data <= texel_data;
      s0_info <= tile_info;
      s0_pidx <= palette_index;
      s0_pval <= palette_value;
    end
  end

  // Operation decode for the current step
  op_t                   op;
  logic [PAL_AW-1:0]     op_addr;
  logic [7:0]            pbyte;
  logic [7:0]            pidx;
  logic [ADDR_SUM_W-1:0] base8;
  logic [ADDR_SUM_W-1:0] base4;
  logic [ADDR_SUM_W-1:0] addr_sum;
  logic [STEP_W-1:0]     blk_slot;

  assign pbyte    = s0_data[7:0];
  assign base8    = ADDR_SUM_W'({pal_window, 3'b000});
  assign base4    = ADDR_SUM_W'({pal_window, 2'b00});
  assign blk_slot = step - STEP_W'(n_reads);

  always_comb begin
    op       = '0;
    op.kind  = OP_NONE;
    op.mode  = blk_mode_t'(s0_info[15:14]);
    op.alpha = 8'hFF;
    op.last  = s0_last;
    pidx     = pbyte;
    addr_sum = base8 + ADDR_SUM_W'(pidx);
    if (s0_cmd == CMD_PAL_WRITE) begin
      op.kind  = OP_WRITE;
      addr_sum = ADDR_SUM_W'(s0_pidx);
    end else begin
      unique case (texture_format)
        FMT_NONE: begin
          op.kind = OP_NONE;
        end
        FMT_A3I5: begin
          op.kind  = OP_EMIT_PAL;
          pidx     = {3'b000, pbyte[4:0]};
          op.alpha = {pbyte[7:5], pbyte[7:5], pbyte[7:6]};
          addr_sum = base8 + ADDR_SUM_W'(pidx);
        end
        FMT_A5I3: begin
          op.kind  = OP_EMIT_PAL;
          pidx     = {5'b00000, pbyte[2:0]};
          op.alpha = {pbyte[7:3], pbyte[7:5]};
          addr_sum = base8 + ADDR_SUM_W'(pidx);
        end
        FMT_PAL8: begin
          op.kind  = OP_EMIT_PAL;
          pidx     = pbyte;
          op.clear = zero_is_clear && (pidx == 8'd0);
          addr_sum = base8 + ADDR_SUM_W'(pidx);
        end
        FMT_PAL4: begin
          op.kind  = OP_EMIT_PAL;
          op.slot  = step[3:0];
          pidx     = {4'b0000, (step[0] ? pbyte[7:4] : pbyte[3:0])};
          op.clear = zero_is_clear && (pidx == 8'd0);
          addr_sum = base8 + ADDR_SUM_W'(pidx);
        end
        FMT_PAL2: begin
          op.kind  = OP_EMIT_PAL;
          op.slot  = step[3:0];
          pidx     = {6'b000000, pbyte[{step[1:0], 1'b0} +: 2]};
          op.clear = zero_is_clear && (pidx == 8'd0);
          addr_sum = base4 + ADDR_SUM_W'(pidx);
        end
        FMT_BLOCK: begin
          addr_sum = base8 + ADDR_SUM_W'({s0_info[13:0], 1'b0}) + ADDR_SUM_W'(step);
          if (step < STEP_W'(n_reads)) begin
            op.kind = OP_LOAD;
            op.sel  = step[1:0];
          end else begin
            op.kind = OP_EMIT_BLOCK;
            op.slot = blk_slot[3:0];
            op.sel  = s0_data[{blk_slot[3:0], 1'b0} +: 2];
          end
        end
        FMT_DIRECT: begin
          op.kind  = OP_EMIT_DIRECT;
          op.color = s0_data[14:0];
          op.alpha = {8{s0_data[15]}};
        end
        default: op.kind = OP_NONE;
      endcase
    end
    op_addr = addr_sum[PAL_AW-1:0];
  end

  // Palette RAM: one write or one registered read per cycle while advancing
  logic [15:0] pal_mem [PALETTE_ENTRIES];
  logic [15:0] s1_rdata;

  always_ff @(posedge clk) begin
    if (adv && s0_valid) begin
      if (op.kind == OP_WRITE) begin
        pal_mem[op_addr] <= s0_pval;
      end else begin
        s1_rdata <= pal_mem[op_addr];
      end
    end
  end

  // Read stage
  logic s1_valid;
  op_t  s1_op;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op <= op;
    end
  end

  // Block colour set, loaded in order ahead of the block's texels
  logic [14:0] blk_col [4];

  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_op.kind == OP_LOAD) begin
      blk_col[s1_op.sel] <= s1_rdata[14:0];
    end
  end

  // Texel colour
  logic [31:0] c0_argb;
  logic [31:0] c1_argb;
  logic [31:0] blk_color;
  logic [31:0] s2_color;
  logic        s1_emit;

  assign c0_argb = to_argb(blk_col[0], 8'hFF);
  assign c1_argb = to_argb(blk_col[1], 8'hFF);

  always_comb begin
    unique case (s1_op.sel)
      2'd0: blk_color = c0_argb;
      2'd1: blk_color = c1_argb;
      2'd2: begin
        unique case (s1_op.mode)
          MODE_AVG:     blk_color = blend_avg(c0_argb, c1_argb);
          MODE_BLEND53: blk_color = blend_53(c0_argb, c1_argb);
          default:      blk_color = to_argb(blk_col[2], 8'hFF);
        endcase
      end
      default: begin
        unique case (s1_op.mode)
          MODE_FOUR:    blk_color = to_argb(blk_col[3], 8'hFF);
          MODE_BLEND53: blk_color = blend_53(c1_argb, c0_argb);
          default:      blk_color = 32'h0000_0000;
        endcase
      end
    endcase
  end

  always_comb begin
    unique case (s1_op.kind)
      OP_EMIT_PAL:    s2_color = s1_op.clear ? 32'h0000_0000
                                             : to_argb(s1_rdata[14:0], s1_op.alpha);
      OP_EMIT_DIRECT: s2_color = to_argb(s1_op.color, s1_op.alpha);
      OP_EMIT_BLOCK:  s2_color = blk_color;
      default:        s2_color = 32'h0000_0000;
    endcase
  end

  assign s1_emit = (s1_op.kind == OP_EMIT_PAL) || (s1_op.kind == OP_EMIT_DIRECT) ||
                   (s1_op.kind == OP_EMIT_BLOCK);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      texel_color <= s2_color;
      texel_slot  <= s1_op.slot;
      last_texel  <= s1_op.last;
    end
  end

  // Checks
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    s0_valid |-> (step < STEP_W'(MAX_OPS)))
    else $error("issue step out of range");

  a_ready_needs_adv: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (!out_valid || out_ready))
    else $error("request taken while pipeline stalled");

  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s0_valid && (step == '0))
    else $error("accepted request not held in issue stage");

  a_block_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op.kind == OP_EMIT_BLOCK) |-> (s1_op.last == (s1_op.slot == 4'd15)))
    else $error("block texel last flag does not match slot");

endmodule

>>> dv/palette_texel_decoder_checker.sv
// ----------------------------------------------------------------------------
// palette_texel_decoder_checker - texel stream predictor and scoreboard
// Watches the register, request and texel channels of the decoder. Each
// accepted request updates a local palette copy or predicts its texels. Each
// accepted texel is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module palette_texel_decoder_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ptd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            command,
  input  logic [31:0]                     texel_data,
  input  logic [15:0]                     tile_info,
  input  logic [15:0]                     palette_index,
  input  logic [15:0]                     palette_value,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [31:0]                     texel_color,
  input  logic [3:0]                      texel_slot,
  input  logic                            last_texel,
  output int                              errors,
  output int                              texels_owed
);
  import ptd_pkg::*;

  typedef struct {
    logic [31:0] color;
    logic [3:0]  slot;
    logic        last;
  } texel_t;

  // local copy of the palette and the registers
  logic [15:0] pal_mem [PALETTE_ENTRIES];
  fmt_t        tex_fmt;
  logic [12:0] pal_base;
  logic        clear0;

  texel_t      texel_q [$];
  texel_t      want;

  // 5-bit channel widened by bit replication
  function automatic logic [7:0] widen5(input logic [4:0] c);
    int v;
    v = int'(c);
    return 8'((v << 3) | (v >> 2));
  endfunction

  // BGR555 to ARGB8888, red from the low bits
  function automatic logic [31:0] argb_of(input logic [14:0] c, input logic [7:0] a);
    return {a, widen5(c[4:0]), widen5(c[9:5]), widen5(c[14:10])};
  endfunction

  // weighted per-channel mix of two colours, always opaque
  function automatic logic [31:0] mix(input logic [31:0] c0, input logic [31:0] c1,
                                      input int w0, input int w1, input int sh);
    logic [31:0] r;
    int          v;
    r = 32'hFF00_0000;
    for (int s = 0; s < 24; s += 8) begin
      v = (int'(c0[s +: 8]) * w0 + int'(c1[s +: 8]) * w1) >> sh;
      r[s +: 8] = v[7:0];
    end
    return r;
  endfunction

  // bit 15 of a stored entry is never used
  function automatic logic [14:0] pal_colour(input logic [15:0] addr);
    return pal_mem[addr][14:0];
  endfunction

  function automatic logic [31:0] indexed(input logic [15:0] base, input logic [7:0] idx);
    if (clear0 && idx == 8'd0) return 32'h0000_0000;
    return argb_of(pal_colour(16'(base + idx)), 8'hFF);
  endfunction

  function automatic void queue_texel(input logic [31:0] color, input int slot, input bit last);
    texel_t t;
    t.color = color;
    t.slot  = 4'(slot);
    t.last  = last;
    texel_q.push_back(t);
  endfunction

  // texels that one decode request produces under the current registers
  task automatic decode_texels(input logic [31:0] data, input logic [15:0] info);
    logic [7:0]  b;
    logic [15:0] base8;
    logic [15:0] base4;
    logic [15:0] pb;
    logic [31:0] quad [4];
    logic [2:0]  a3;
    logic [4:0]  a5;
    b     = data[7:0];
    base8 = {pal_base, 3'b000};
    base4 = {1'b0, pal_base, 2'b00};
    case (tex_fmt)
      FMT_A3I5: begin
        a3 = b[7:5];
        queue_texel(argb_of(pal_colour(16'(base8 + b[4:0])), {a3, a3, a3[2:1]}), 0, 1'b1);
      end
      FMT_A5I3: begin
        a5 = b[7:3];
        queue_texel(argb_of(pal_colour(16'(base8 + b[2:0])), {a5, a5[4:2]}), 0, 1'b1);
      end
      FMT_PAL2: begin
        for (int k = 0; k < 4; k++)
          queue_texel(indexed(base4, 8'(b[2*k +: 2])), k, k == 3);
      end
      FMT_PAL4: begin
        for (int k = 0; k < 2; k++)
          queue_texel(indexed(base8, 8'(b[4*k +: 4])), k, k == 1);
      end
      FMT_PAL8: queue_texel(indexed(base8, b), 0, 1'b1);
      FMT_BLOCK: begin
        pb      = 16'(base8 + {info[13:0], 1'b0});
        quad[0] = argb_of(pal_colour(pb), 8'hFF);
        quad[1] = argb_of(pal_colour(16'(pb + 16'd1)), 8'hFF);
        case (info[15:14])
          MODE_P3_ZERO: begin
            quad[2] = argb_of(pal_colour(16'(pb + 16'd2)), 8'hFF);
            quad[3] = 32'h0;
          end
          MODE_AVG: begin
            quad[2] = mix(quad[0], quad[1], 1, 1, 1);
            quad[3] = 32'h0;
          end
          MODE_FOUR: begin
            quad[2] = argb_of(pal_colour(16'(pb + 16'd2)), 8'hFF);
            quad[3] = argb_of(pal_colour(16'(pb + 16'd3)), 8'hFF);
          end
          default: begin
            quad[2] = mix(quad[0], quad[1], 5, 3, 3);
            quad[3] = mix(quad[0], quad[1], 3, 5, 3);
          end
        endcase
        for (int k = 0; k < 16; k++)
          queue_texel(quad[data[2*k +: 2]], k, k == 15);
      end
      FMT_DIRECT: queue_texel(argb_of(data[14:0], data[15] ? 8'hFF : 8'h00), 0, 1'b1);
      default: ;
    endcase
  endtask

  // all three channels sampled on the same edge the design sees them
  always @(posedge clk) begin
    if (rst) begin
      tex_fmt  = FMT_NONE;
      pal_base = '0;
      clear0   = 1'b0;
      errors   = 0;
      texel_q.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXTURE_FORMAT: tex_fmt  = fmt_t'(cfg_data[2:0]);
          CFG_PALETTE_BASE:   pal_base = cfg_data[12:0];
          CFG_COLOR0_TRANSP:  clear0   = cfg_data[0];
          default: ;
        endcase
      end
      // requests
      if (in_valid && in_ready) begin
        if (command == CMD_PAL_WRITE)
          pal_mem[palette_index] = palette_value;
        else
          decode_texels(texel_data, tile_info);
      end
      // texels
      if (out_valid && out_ready) begin
        if (texel_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected texel: color %h slot %0d last %0d",
                     texel_color, texel_slot, last_texel);
        end else begin
          want = texel_q.pop_front();
          if (texel_color !== want.color || texel_slot !== want.slot ||
              last_texel !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("texel mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                       want.color, want.slot, want.last,
                       texel_color, texel_slot, last_texel);
          end
        end
      end
    end
    texels_owed = texel_q.size();
  end

endmodule

>>> dv/palette_texel_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// palette_texel_decoder_unit_test - testbench top for the texel decoder
// Drives palette writes and decode requests, reprograms the registers between
// phases and varies idling on both sides; the checker beside the design
// predicts and compares every texel.
// ----------------------------------------------------------------------------
module palette_texel_decoder_unit_test;
  import ptd_pkg::*;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 14;
  localparam int LONG_STALL      = 400;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic                  command       = 1'b0;
  logic [31:0]           texel_data    = '0;
  logic [15:0]           tile_info     = '0;
  logic [15:0]           palette_index = '0;
  logic [15:0]           palette_value = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [31:0]           texel_color;
  logic [3:0]            texel_slot;
  logic                  last_texel;

  int errors;
  int texels_owed;
  int cycle_count  = 0;
  int send_gap_pct = 6;
  int recv_gap_pct = 69;
  int stall_asked  = 0;
  int stall_taken  = 0;
  int stall_left   = 0;
  int items_sent   = 0;

  // register mirror and record of written palette entries
  fmt_t        cur_fmt   = FMT_NONE;
  logic [12:0] cur_base  = '0;
  bit          pal_written [PALETTE_ENTRIES];

  palette_texel_decoder_unit u_dut (.*);

  palette_texel_decoder_checker u_checker (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // texel sink: random back-pressure, or a long hold-off when asked
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_asked != stall_taken) begin
      out_ready   <= 1'b0;
      stall_left  <= LONG_STALL;
      stall_taken <= stall_asked;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // one request, held until taken; valid is only lowered for an idle gap
  task automatic offer(input cmd_t cmd, input logic [31:0] data, input logic [15:0] info,
                       input logic [15:0] idx, input logic [15:0] val);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    texel_data    <= data;
    tile_info     <= info;
    palette_index <= idx;
    palette_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_PAL_WRITE) pal_written[idx] = 1'b1;
    items_sent++;
  endtask

  task automatic write_entry(input logic [15:0] idx, input logic [15:0] val);
    offer(CMD_PAL_WRITE, $urandom, 16'($urandom), idx, val);
  endtask

  // decode request; any palette entry it reads is written first if still blank
  task automatic decode(input logic [31:0] data, input logic [15:0] info);
    logic [15:0] need [4];
    logic [15:0] b8;
    logic [15:0] pb;
    int          n;
    b8 = {cur_base, 3'b000};
    n  = 0;
    case (cur_fmt)
      FMT_A3I5: begin need[0] = 16'(b8 + data[4:0]); n = 1; end
      FMT_A5I3: begin need[0] = 16'(b8 + data[2:0]); n = 1; end
      FMT_PAL8: begin need[0] = 16'(b8 + data[7:0]); n = 1; end
      FMT_PAL4: begin
        need[0] = 16'(b8 + data[3:0]);
        need[1] = 16'(b8 + data[7:4]);
        n = 2;
      end
      FMT_PAL2: begin
        for (int k = 0; k < 4; k++)
          need[k] = 16'({1'b0, cur_base, 2'b00} + data[2*k +: 2]);
        n = 4;
      end
      FMT_BLOCK: begin
        pb = 16'(b8 + {info[13:0], 1'b0});
        for (int k = 0; k < 4; k++)
          need[k] = 16'(pb + k);
        n = 4;
      end
      default: n = 0;
    endcase
    for (int k = 0; k < n; k++)
      if (!pal_written[need[k]]) write_entry(need[k], 16'($urandom));
    offer(CMD_DECODE, data, info, 16'($urandom), 16'($urandom));
  endtask

  // stop requesting, wait for every texel, then let trailing writes retire
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (texels_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input fmt_t f, input logic [12:0] b, input logic c);
    settle();
    set_reg(CFG_TEXTURE_FORMAT, 13'(f));
    set_reg(CFG_PALETTE_BASE, b);
    set_reg(CFG_COLOR0_TRANSP, 13'(c));
    cfg_valid <= 1'b0;
    cur_fmt   = f;
    cur_base  = b;
  endtask

  // mostly decodes; some writes land inside the live palette window
  task automatic random_item();
    logic [15:0] idx;
    if ($urandom_range(99) < 15) begin
      if ($urandom_range(1) == 0)
        idx = 16'($urandom);
      else
        idx = 16'({cur_base, 3'b000} + $urandom_range(255));
      write_entry(idx, 16'($urandom));
    end else begin
      decode($urandom, 16'($urandom));
    end
  endtask

  initial begin
    fmt_t f;
    logic [12:0] b;
    int phase_end;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: palette extremes and format none
    write_entry(16'h0000, 16'hFFFF);
    write_entry(16'hFFFF, 16'h8000);
    write_entry(16'h0001, 16'h7FFF);
    write_entry(16'h0002, 16'h0000);
    write_entry(16'h0003, 16'h801F);
    decode(32'hFFFF_FFFF, 16'hFFFF);

    // direct colour, with and without alpha
    configure(FMT_DIRECT, 13'h0000, 1'b0);
    decode(32'hFFFF_FFFF, 16'h0000);
    decode(32'h0000_0000, 16'h0000);
    decode(32'h0000_7FFF, 16'h0000);

    // pal8 at the top base: transparent index zero and address wrap
    configure(FMT_PAL8, 13'h1FFF, 1'b1);
    decode(32'h0000_0000, 16'h0000);
    decode(32'h0000_00FF, 16'h0000);

    configure(FMT_A3I5, 13'h0000, 1'b0);
    decode(32'h0000_00FF, 16'h0000);
    decode(32'h0000_0000, 16'h0000);

    configure(FMT_A5I3, 13'h0000, 1'b0);
    decode(32'h0000_00FF, 16'h0000);
    decode(32'h0000_0000, 16'h0000);

    configure(FMT_PAL2, 13'h0000, 1'b1);
    decode(32'h0000_00E4, 16'h0000);

    configure(FMT_PAL4, 13'h1FFF, 1'b0);
    decode(32'h0000_00F0, 16'h0000);

    // compressed block: each mode, offsets at both ends
    configure(FMT_BLOCK, 13'h1FFF, 1'b0);
    decode(32'hE4E4_E4E4, {MODE_P3_ZERO, 14'h3FFF});
    decode(32'h1B1B_1B1B, {MODE_AVG, 14'h0000});
    decode(32'hE4E4_E4E4, {MODE_FOUR, 14'h3FFF});
    decode(32'h1B1B_E4E4, {MODE_BLEND53, 14'h0000});

    // random phases under changing registers and idling
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        send_gap_pct = 6;
        recv_gap_pct <= 69;
      end else if (p == 4) begin
        send_gap_pct = 69;
        recv_gap_pct <= 6;
      end else if (p == 8) begin
        send_gap_pct = 0;
        recv_gap_pct <= 0;
      end
      if (p < 7)
        f = fmt_t'(3'(p + 1));
      else
        f = fmt_t'(3'($urandom_range(7, 1)));
      case (p % 4)
        0:       b = 13'h0000;
        1:       b = 13'h1FFF;
        default: b = 13'($urandom);
      endcase
      configure(f, b, (p % 3) == 1);
      // long sink hold-off while requests keep coming
      if (p == 4) stall_asked <= stall_asked + 1;
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end)
        random_item();
    end

    settle();
    if (errors == 0 && texels_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

>>> filelist.f
design/ptd_pkg.sv
design/palette_texel_decoder_unit.sv
dv/palette_texel_decoder_checker.sv
dv/palette_texel_decoder_unit_test.sv
